FILE: hdl/i2cdwf_pkg.sv
// ----------------------------------------------------------------------------
// I2C display write framer package
// Shared types, bus constants and the frame byte selection function.
// ----------------------------------------------------------------------------
package i2cdwf_pkg;

    localparam logic [7:0] CTRL_COMMAND = 8'h00;
    localparam logic [7:0] CTRL_DATA    = 8'h40;
    localparam logic [7:0] ADDR_RESET   = 8'h78;

    // Frame byte positions.
    localparam logic [1:0] BYTE_ADDR    = 2'd0;
    localparam logic [1:0] BYTE_CTRL    = 2'd1;
    localparam logic [1:0] BYTE_PAYLOAD = 2'd2;

    // One frame request as it waits for the sequencer.
    typedef struct packed {
        logic       is_display_data;
        logic [7:0] payload_byte;
    } item_t;

    // One half-bit bus phase.
    typedef struct packed {
        logic clock_level;
        logic data_level;
        logic ack_sample;
        logic last_phase;
    } phase_t;

    function automatic logic [7:0] frame_byte(input logic [1:0] idx,
                                              input logic [7:0] addr,
                                              input logic       is_data,
                                              input logic [7:0] payload);
        logic [7:0] b;
        b = payload;
        if (idx == BYTE_ADDR) begin
            b = addr;
        end else if (idx == BYTE_CTRL) begin
            b = is_data ? CTRL_DATA : CTRL_COMMAND;
        end
        return b;
    endfunction

endpackage

FILE: hdl/i2c_display_write_framer_top.sv
// ----------------------------------------------------------------------------
// I2C display write framer
// Turns each write request into the 63 half-bit phases of one I2C frame.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the s_ channel asks for one complete write frame: a start
// condition, the device address byte, a control byte (0x00 for a command,
// 0x40 for display data), the payload byte MSB first, and a stop condition.
// After every byte SDA is released for an acknowledge slot around an SCL high
// pulse so the slave can acknowledge; the ack level is never examined.
// The m_ channel carries one phase per transfer, 63 per frame, in bus order.
// The device address comes from a single register written through the
// cfg_ port; it should only be changed while no frame is pending.
// When the block is idle, an accepted request passes through the input
// register, the sequencer state and the result register before its first
// phase appears. The phase sequencer emits one phase per cycle while the
// receiver takes them. A waiting request is held in an input register, so
// the next frame starts directly after the stop phase of the current one.
// If the receiver stalls, the result register holds its phase and the
// sequencer waits; no phase is dropped. Reset (aresetn low, synchronous)
// empties both registers, idles the sequencer and sets the address to 0x78.
// ----------------------------------------------------------------------------
module i2c_display_write_framer_top (
    input  logic       aclk,
    input  logic       aresetn,
    // Frame requests.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] payload_byte
    input  logic [0:0] s_tuser,   // [0] is_display_data
    // Bus phases.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] clock_level, [1] data_level, [7:2] zero
    output logic [0:0] m_tuser,   // [0] ack_sample
    output logic       m_tlast,   // last_phase
    // Device address register.
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);
    import i2cdwf_pkg::*;

    logic [7:0] addr_reg;
    logic [7:0] addr_next;

    item_t  s_item;
    item_t  held_item;
    logic   held_valid;
    logic   take;
    logic   out_ready;
    logic   res_valid;
    phase_t res;
    phase_t m_phase;

    // The address register accepts a write in every cycle.
    assign cfg_ready = 1'b1;

    always_comb begin
        addr_next = addr_reg;
        if (cfg_valid && cfg_ready) begin
            addr_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= ADDR_RESET;
        end else begin
            addr_reg <= addr_next;
        end
    end

    assign s_item.is_display_data = s_tuser[0];
    assign s_item.payload_byte    = s_tdata;

    i2cdwf_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (held_valid),
        .item       (held_item)
    );

    i2cdwf_phase_gen u_phase_gen (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (held_valid),
        .item       (held_item),
        .addr       (addr_reg),
        .take       (take),
        .out_ready  (out_ready),
        .res_valid  (res_valid),
        .res        (res)
    );

    i2cdwf_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (res_valid),
        .load_data  (res),
        .load_ready (out_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_phase    (m_phase)
    );

    // Pack the phase onto the stream: levels in tdata, ack flag in tuser.
    assign m_tdata = {6'b0, m_phase.data_level, m_phase.clock_level};
    assign m_tuser = m_phase.ack_sample;
    assign m_tlast = m_phase.last_phase;

endmodule

FILE: hdl/i2cdwf_in_stage.sv
// ----------------------------------------------------------------------------
// I2C framer input stage
// Holds one frame request so the next can arrive while a frame is sent.
// ----------------------------------------------------------------------------
module i2cdwf_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  i2cdwf_pkg::item_t   s_item,
    input  logic                take,
    output logic                item_valid,
    output i2cdwf_pkg::item_t   item
);
    import i2cdwf_pkg::*;

    logic  hold_valid_reg;
    logic  hold_valid_next;
    item_t item_reg;
    logic  load;

    assign s_tready   = !hold_valid_reg || take;
    assign load       = s_tvalid && s_tready;
    assign item_valid = hold_valid_reg;
    assign item       = item_reg;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (load) begin
            hold_valid_next = 1'b1;
        end else if (take) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= s_item;
        end
    end

endmodule

FILE: hdl/i2cdwf_phase_gen.sv
// ----------------------------------------------------------------------------
// I2C framer phase sequencer
// Walks start, three bytes with ack slots, and stop, one phase per step.
// ----------------------------------------------------------------------------
module i2cdwf_phase_gen (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  i2cdwf_pkg::item_t   item,
    input  logic [7:0]          addr,
    output logic                take,
    input  logic                out_ready,
    output logic                res_valid,
    output i2cdwf_pkg::phase_t  res
);
    import i2cdwf_pkg::*;

    localparam logic [1:0] SEG_IDLE  = 2'd0;
    localparam logic [1:0] SEG_START = 2'd1;
    localparam logic [1:0] SEG_BYTE  = 2'd2;
    localparam logic [1:0] SEG_STOP  = 2'd3;

    localparam logic [4:0] STEP_EDGE_LAST = 5'd2;
    localparam logic [4:0] STEP_ACK_HIGH  = 5'd17;
    localparam logic [4:0] STEP_BYTE_LAST = 5'd18;

    logic [1:0] seg_reg,      seg_next;
    logic [4:0] step_reg,     step_next;
    logic [1:0] byte_idx_reg, byte_idx_next;
    logic [7:0] shift_reg,    shift_next;
    item_t      frame_reg;

    logic adv;
    logic frame_end;

    assign adv       = (seg_reg != SEG_IDLE) && out_ready;
    assign frame_end = adv && (seg_reg == SEG_STOP) && (step_reg == STEP_EDGE_LAST);
    assign take      = item_valid && ((seg_reg == SEG_IDLE) || frame_end);
    assign res_valid = adv;

    // Bus levels for the current phase.
    always_comb begin
        res = '0;
        case (seg_reg)
            SEG_START: begin
                res.clock_level = (step_reg != STEP_EDGE_LAST);
                res.data_level  = (step_reg == 5'd0);
            end
            SEG_BYTE: begin
                if (!step_reg[4]) begin
                    res.clock_level = !step_reg[0];
                    res.data_level  = shift_reg[7];
                end else begin
                    res.clock_level = (step_reg == STEP_ACK_HIGH);
                    res.data_level  = 1'b1;
                    res.ack_sample  = (step_reg == STEP_ACK_HIGH);
                end
            end
            SEG_STOP: begin
                res.clock_level = (step_reg != 5'd0);
                res.data_level  = (step_reg == STEP_EDGE_LAST);
                res.last_phase  = (step_reg == STEP_EDGE_LAST);
            end
            default: begin
                res = '0;
            end
        endcase
    end

    always_comb begin
        seg_next      = seg_reg;
        step_next     = step_reg;
        byte_idx_next = byte_idx_reg;
        shift_next    = shift_reg;
        case (seg_reg)
            SEG_IDLE: begin
                if (take) begin
                    seg_next  = SEG_START;
                    step_next = '0;
                end
            end
            SEG_START: begin
                if (adv) begin
                    if (step_reg == STEP_EDGE_LAST) begin
                        seg_next      = SEG_BYTE;
                        step_next     = '0;
                        byte_idx_next = BYTE_ADDR;
                        shift_next    = frame_byte(BYTE_ADDR, addr,
                                                   frame_reg.is_display_data,
                                                   frame_reg.payload_byte);
                    end else begin
                        step_next = step_reg + 5'd1;
                    end
                end
            end
            SEG_BYTE: begin
                if (adv) begin
                    // Shift after the SCL-low half of each data bit.
                    if (!step_reg[4] && step_reg[0]) begin
                        shift_next = {shift_reg[6:0], 1'b0};
                    end
                    if (step_reg == STEP_BYTE_LAST) begin
                        step_next = '0;
                        if (byte_idx_reg == BYTE_PAYLOAD) begin
                            seg_next = SEG_STOP;
                        end else begin
                            byte_idx_next = byte_idx_reg + 2'd1;
                            shift_next    = frame_byte(byte_idx_reg + 2'd1, addr,
                                                       frame_reg.is_display_data,
                                                       frame_reg.payload_byte);
                        end
                    end else begin
                        step_next = step_reg + 5'd1;
                    end
                end
            end
            SEG_STOP: begin
                if (adv) begin
                    if (step_reg == STEP_EDGE_LAST) begin
                        step_next = '0;
                        seg_next  = take ? SEG_START : SEG_IDLE;
                    end else begin
                        step_next = step_reg + 5'd1;
                    end
                end
            end
            default: begin
                seg_next = SEG_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg      <= SEG_IDLE;
            step_reg     <= '0;
            byte_idx_reg <= '0;
            shift_reg    <= '0;
        end else begin
            seg_reg      <= seg_next;
            step_reg     <= step_next;
            byte_idx_reg <= byte_idx_next;
            shift_reg    <= shift_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            frame_reg <= item;
        end
    end

    // A new frame is only taken when the sequencer is free or finishing.
    a_take_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> ((seg_reg == SEG_IDLE) || frame_end))
        else $error("frame taken while sequencer busy");

    a_byte_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (seg_reg == SEG_BYTE) |-> (byte_idx_reg != 2'd3))
        else $error("byte index out of range");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((seg_reg == SEG_BYTE) |-> (step_reg <= STEP_BYTE_LAST)) and
        (((seg_reg == SEG_START) || (seg_reg == SEG_STOP)) |->
            (step_reg <= STEP_EDGE_LAST)))
        else $error("phase step out of range");

    a_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && res.last_phase) |=> ((seg_reg == SEG_IDLE) || (seg_reg == SEG_START)))
        else $error("sequencer not restarted after stop");

    a_ack_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && res.ack_sample) |-> (res.clock_level && res.data_level &&
                                     (seg_reg == SEG_BYTE)))
        else $error("ack sample outside released SCL-high phase");

endmodule

FILE: hdl/i2cdwf_out_reg.sv
// ----------------------------------------------------------------------------
// I2C framer result register
// Holds one phase for the receiver; reloads whenever it is empty or taken.
// ----------------------------------------------------------------------------
module i2cdwf_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  i2cdwf_pkg::phase_t  load_data,
    output logic                load_ready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output i2cdwf_pkg::phase_t  m_phase
);
    import i2cdwf_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    phase_t data_reg;

    assign load_ready = !valid_reg || m_tready;
    assign m_tvalid   = valid_reg;
    assign m_phase    = data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

endmodule

FILE: tb/frame_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C write frame tracker
// Builds the 63 expected bus phases of each accepted write request and
// compares the phases coming out of the framer against them in order.
// ----------------------------------------------------------------------------
import i2cdwf_pkg::*;

class frame_tracker;

    logic [7:0]  device_address;
    phase_t      pending_phases[$];
    int unsigned mismatches;
    int unsigned phases_checked;

    function new();
        device_address = ADDR_RESET;
        mismatches     = 0;
        phases_checked = 0;
    endfunction

    function void set_address(logic [7:0] addr);
        device_address = addr;
    endfunction

    function void push_phase(logic scl, logic sda, logic ack, logic last);
        phase_t ph;
        ph.clock_level = scl;
        ph.data_level  = sda;
        ph.ack_sample  = ack;
        ph.last_phase  = last;
        pending_phases.push_back(ph);
    endfunction

    // Eight data bits MSB first, then the released acknowledge slot.
    function void push_byte(logic [7:0] value);
        for (int i = 7; i >= 0; i--) begin
            push_phase(1'b1, value[i], 1'b0, 1'b0);
            push_phase(1'b0, value[i], 1'b0, 1'b0);
        end
        push_phase(1'b0, 1'b1, 1'b0, 1'b0);
        push_phase(1'b1, 1'b1, 1'b1, 1'b0);
        push_phase(1'b0, 1'b1, 1'b0, 1'b0);
    endfunction

    function void note_request(logic is_data, logic [7:0] payload);
        push_phase(1'b1, 1'b1, 1'b0, 1'b0);
        push_phase(1'b1, 1'b0, 1'b0, 1'b0);
        push_phase(1'b0, 1'b0, 1'b0, 1'b0);
        push_byte(device_address);
        push_byte(is_data ? CTRL_DATA : CTRL_COMMAND);
        push_byte(payload);
        push_phase(1'b0, 1'b0, 1'b0, 1'b0);
        push_phase(1'b1, 1'b0, 1'b0, 1'b0);
        push_phase(1'b1, 1'b1, 1'b0, 1'b1);
    endfunction

    function int unsigned pending();
        return pending_phases.size();
    endfunction

    task report(string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_phase(phase_t got);
        phase_t      want;
        int unsigned slot;
        slot = phases_checked % 63;
        phases_checked++;
        if (pending_phases.size() == 0) begin
            report($sformatf("phase %b arrived with no frame pending", got));
        end else begin
            want = pending_phases.pop_front();
            if (got.clock_level !== want.clock_level)
                report($sformatf("slot %0d SCL %b, wanted %b", slot,
                                 got.clock_level, want.clock_level));
            if (got.data_level !== want.data_level)
                report($sformatf("slot %0d SDA %b, wanted %b", slot,
                                 got.data_level, want.data_level));
            if (got.ack_sample !== want.ack_sample)
                report($sformatf("slot %0d ack flag %b, wanted %b", slot,
                                 got.ack_sample, want.ack_sample));
            if (got.last_phase !== want.last_phase)
                report($sformatf("slot %0d last flag %b, wanted %b", slot,
                                 got.last_phase, want.last_phase));
        end
    endtask

endclass

FILE: tb/i2c_display_write_framer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C display write framer testbench
// Drives write requests and device address changes into the framer and
// checks every bus phase it emits against an independent frame builder,
// under random idling on both channels, a long receiver stall and drains.
// ----------------------------------------------------------------------------
import i2cdwf_pkg::*;

module i2c_display_write_framer_top_tb;

    // Cycles without any transfer on any channel before the run is declared
    // hung. The long receiver stall below is the worst legitimate quiet spell.
    localparam int unsigned QUIET_LIMIT  = 4000;
    localparam int unsigned STALL_CYCLES = 600;
    localparam int unsigned STALL_AT     = 150;
    localparam int unsigned RANDOM_COUNT = 500;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;
    logic [0:0] s_tuser   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic [0:0] m_tuser;
    logic       m_tlast;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = 8'h00;

    frame_tracker tracker;

    // When calm is set, neither side inserts random idle cycles.
    bit          calm          = 1'b0;
    bit          sending       = 1'b0;
    int unsigned requests_seen = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned stall_left    = 0;
    bit          stall_done    = 1'b0;

    i2c_display_write_framer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // The receiver accepts phases with random idle cycles. Once enough
    // requests have gone in it refuses everything for a long stretch, so the
    // framer's input register fills and s_tready must drop while the sender
    // keeps offering.
    always @(posedge aclk) begin
        if (!stall_done && requests_seen >= STALL_AT) begin
            stall_left = STALL_CYCLES;
            stall_done = 1'b1;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(0, 99) >= 20);
        end
    end

    // Monitor: all channels are sampled at the clock edge, where the values
    // seen are the ones the block saw. Phases are checked before a request
    // taken at the same edge is noted, since no phase can belong to a request
    // accepted at that very edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                tracker.check_phase({m_tdata[0], m_tdata[1], m_tuser[0], m_tlast});
            end
            if (s_tvalid && s_tready) begin
                tracker.note_request(s_tuser[0], s_tdata);
                requests_seen++;
            end
            if (cfg_valid && cfg_ready) begin
                tracker.set_address(cfg_data);
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) ||
                (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Offers one write request and returns at the edge where it is taken.
    // The valid line stays high on return so back-to-back requests need no
    // gap; stop_sending lowers it when the sender goes quiet.
    task send_frame(input logic is_data, input logic [7:0] payload);
        if (!calm && $urandom_range(0, 99) < 20) begin
            if (sending) begin
                s_tvalid <= 1'b0;
                sending = 1'b0;
            end
            @(posedge aclk);
            while ($urandom_range(0, 99) < 20) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= payload;
        s_tuser  <= is_data;
        sending = 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task stop_sending();
        if (sending) begin
            s_tvalid <= 1'b0;
            sending = 1'b0;
        end
    endtask

    // Stops offering and waits until every expected phase has come out, at
    // which point the framer has nothing left to do.
    task drain();
        stop_sending();
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
    endtask

    // The device address is only changed with the framer idle.
    task write_address(input logic [7:0] addr);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= addr;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task send_random(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            send_frame(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        tracker = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset address: both control bytes, all-zero
        // and all-one payloads, alternating bits, and single set bits at
        // each end of the byte.
        send_frame(1'b0, 8'h00);
        send_frame(1'b1, 8'hFF);
        send_frame(1'b0, 8'hA5);
        send_frame(1'b1, 8'h5A);
        send_frame(1'b1, 8'h80);
        send_frame(1'b0, 8'h01);
        send_frame(1'b0, 8'hFF);
        send_frame(1'b1, 8'h00);

        // Address extremes, with frames of both kinds under each.
        write_address(8'h00);
        send_frame(1'b0, 8'hC3);
        send_frame(1'b1, 8'h3C);
        send_frame(1'b1, 8'hFF);
        send_frame(1'b0, 8'h00);
        write_address(8'hFF);
        send_frame(1'b1, 8'h00);
        send_frame(1'b0, 8'hFF);
        send_frame(1'b1, 8'h69);
        send_frame(1'b0, 8'h96);
        write_address(8'hAA);
        send_frame(1'b0, 8'h55);
        send_frame(1'b1, 8'hAA);

        // Random part. The receiver's long stall falls inside the second
        // block, which otherwise runs with no idling on either side; the
        // sender pauses for a full drain in the third.
        write_address(8'($urandom_range(0, 255)));
        send_random(RANDOM_COUNT / 4);
        write_address(8'h78);
        calm = 1'b1;
        send_random(RANDOM_COUNT / 4);
        calm = 1'b0;
        write_address(8'($urandom_range(0, 255)));
        send_random(RANDOM_COUNT / 8);
        drain();
        send_random(RANDOM_COUNT / 8);
        write_address(8'($urandom_range(0, 255)));
        send_random(RANDOM_COUNT / 4);

        drain();
        // A short tail to catch any phase the framer emits beyond a frame.
        repeat (20) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/i2cdwf_pkg.sv
hdl/i2cdwf_in_stage.sv
hdl/i2cdwf_phase_gen.sv
hdl/i2cdwf_out_reg.sv
hdl/i2c_display_write_framer_top.sv
tb/frame_tracker.sv
tb/i2c_display_write_framer_top_tb.sv
